FILE: src/h2f_pkg.sv
// Shared types and constants for the H.264 Annex-B to FLV video tag converter.
// No dependencies.
package h2f_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REC,
    ST_FRM,
    ST_DATA
  } h2f_state_t;

  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;

  localparam logic [7:0] TAG_KEY      = 8'h17;
  localparam logic [7:0] TAG_INTER    = 8'h27;
  localparam logic [7:0] BYTE_ONE     = 8'h01;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] BYTE_FF      = 8'hFF;
  localparam logic [7:0] BYTE_E1      = 8'hE1;

  // record header bytes before the SPS body, and fixed record overhead
  localparam int REC_PRE   = 13;
  localparam int REC_FIXED = 16;
  // frame header length
  localparam int FRM_HDR   = 9;

  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  // Per-transfer decision from the parser to the emitter
  typedef struct packed {
    logic        rec;       // emit configuration record header
    logic        frm;       // emit frame header
    logic        data;      // pass the byte through
    logic        last;      // byte ends the unit
    logic        kind;      // 0 record, 1 frame
    logic        trunc;     // SPS overflow flag for record bytes
    logic [7:0]  tag;       // first frame header byte
    logic [7:0]  byte_val;
    logic [23:0] body_len;  // announced body length
    logic [23:0] hdr_len;   // payload length carried in the header
  } h2f_dec_t;

endpackage

FILE: src/h2f_sps_mem.sv
// SPS byte store: one write port, one registered read port.
// Depends on nothing.
module h2f_sps_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // addresses past the store read nothing useful; hold the last value
  always_ff @(posedge clk) begin
    if (32'(raddr) < DEPTH) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/h2f_parse.sv
// Per-byte parser: unit position, type, start code length and SPS bookkeeping.
// Depends on h2f_pkg; drives the write port of h2f_sps_mem.
module h2f_parse #(
  parameter int SPS_MAX = 32,
  parameter int CW      = 6,
  parameter int AW      = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            acc,
  input  logic [4:0]      nal_type,
  input  logic [23:0]     nal_length,
  input  logic [7:0]      byte_value,
  input  logic            byte_last,
  output h2f_pkg::h2f_dec_t dec,
  output logic            we,
  output logic [AW-1:0]   waddr,
  output logic [7:0]      wdata,
  output logic [CW-1:0]   sps_count
);
  import h2f_pkg::*;

  logic [23:0]   byte_position, byte_position_next;
  logic [4:0]    unit_type, unit_type_next;
  logic [CW-1:0] sps_count_next;
  logic          sps_overflow, sps_overflow_next;
  logic          start_code_long, start_code_long_next;

  logic          first_pos;
  logic          sps_room;
  logic [23:0]   pps_len, plen;
  logic [24:0]   rec_total, frm_total;
  logic          is_sps, is_pps;

  always_comb begin
    first_pos            = (byte_position == 24'd0);
    unit_type_next       = first_pos ? nal_type : unit_type;
    is_sps               = (unit_type_next == NAL_SPS);
    is_pps               = (unit_type_next == NAL_PPS);
    sps_room             = (sps_count < CW'(SPS_MAX));

    sps_count_next       = sps_count;
    sps_overflow_next    = sps_overflow;
    start_code_long_next = start_code_long;
    we                   = 1'b0;
    waddr                = sps_count[AW-1:0];
    wdata                = byte_value;

    dec          = '0;
    dec.last     = byte_last;
    dec.byte_val = byte_value;

    pps_len   = (nal_length >= 24'd4) ? nal_length - 24'd4 : 24'd0;
    rec_total = {1'b0, pps_len} + 25'(sps_count) + 25'(REC_FIXED);
    plen      = 24'd0;
    frm_total = '0;

    if (is_sps) begin
      if (first_pos) begin
        sps_count_next    = '0;
        sps_overflow_next = 1'b0;
      end else if (byte_position >= 24'd4) begin
        if (sps_room) begin
          we             = acc;
          sps_count_next = sps_count + CW'(1);
        end else begin
          sps_overflow_next = 1'b1;
        end
      end
    end else if (is_pps) begin
      dec.kind     = 1'b0;
      dec.trunc    = sps_overflow;
      dec.rec      = (byte_position == 24'd3) || (byte_position < 24'd3 && byte_last);
      dec.data     = (byte_position >= 24'd4);
      dec.hdr_len  = pps_len;
      dec.body_len = rec_total[24] ? MAX24 : rec_total[23:0];
    end else begin
      if (first_pos) begin
        start_code_long_next = 1'b0;
      end else if (byte_position == 24'd2) begin
        start_code_long_next = (byte_value == BYTE_ZERO);
      end
      plen = start_code_long_next
           ? ((nal_length >= 24'd4) ? nal_length - 24'd4 : 24'd0)
           : ((nal_length >= 24'd3) ? nal_length - 24'd3 : 24'd0);
      frm_total    = {1'b0, plen} + 25'(FRM_HDR);
      dec.kind     = 1'b1;
      dec.frm      = (byte_position == 24'd2 && (!start_code_long_next || byte_last))
                   || (byte_position == 24'd3 && start_code_long_next)
                   || (byte_position < 24'd2 && byte_last);
      dec.data     = (byte_position >= 24'd3)
                   && (!start_code_long_next || byte_position >= 24'd4);
      dec.tag      = (unit_type_next == NAL_IDR) ? TAG_KEY : TAG_INTER;
      dec.hdr_len  = plen;
      dec.body_len = frm_total[24] ? MAX24 : frm_total[23:0];
    end

    if (byte_last) begin
      byte_position_next = 24'd0;
    end else if (byte_position != MAX24) begin
      byte_position_next = byte_position + 24'd1;
    end else begin
      byte_position_next = byte_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      unit_type       <= '0;
      sps_count       <= '0;
      sps_overflow    <= 1'b0;
      start_code_long <= 1'b0;
    end else if (acc) begin
      byte_position   <= byte_position_next;
      unit_type       <= unit_type_next;
      sps_count       <= sps_count_next;
      sps_overflow    <= sps_overflow_next;
      start_code_long <= start_code_long_next;
    end
  end

endmodule

FILE: src/h2f_emit.sv
// Header sequencer and output register; reads the SPS store one entry ahead.
// Depends on h2f_pkg; reads h2f_sps_mem.
module h2f_emit #(
  parameter int CW = 6,
  parameter int AW = 5,
  parameter int IW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  h2f_pkg::h2f_dec_t dec,
  input  logic [CW-1:0]     sps_count,
  input  logic [7:0]        rd_data,
  output logic [AW-1:0]     rd_addr,
  output logic              idle_ok,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        out_byte,
  output logic              packet_first,
  output logic              packet_last,
  output logic              packet_kind,
  output logic [23:0]       body_length,
  output logic              sps_truncated
);
  import h2f_pkg::*;

  h2f_state_t    state, state_next;
  logic [IW-1:0] idx, idx_next;
  h2f_dec_t      q;

  logic          out_ok;
  logic          emit;
  logic [7:0]    e_byte;
  logic          e_first, e_last, e_kind, e_trunc;
  logic [23:0]   e_blen;
  logic [IW-1:0] rec_end, off;
  logic [7:0]    rec_byte, frm_byte;
  logic [15:0]   count16;

  assign out_ok  = !m_tvalid || m_tready;
  assign idle_ok = (state == ST_IDLE) && out_ok;
  assign rec_end = IW'(REC_FIXED - 1) + IW'(sps_count);
  assign count16 = 16'(sps_count);

  // record header byte at idx
  always_comb begin
    off = idx - IW'(REC_PRE);
    case (idx)
      IW'(0):  rec_byte = TAG_KEY;
      IW'(5):  rec_byte = BYTE_ONE;
      IW'(6),
      IW'(7),
      IW'(8):  rec_byte = rd_data;
      IW'(9):  rec_byte = BYTE_FF;
      IW'(10): rec_byte = BYTE_E1;
      IW'(11): rec_byte = count16[15:8];
      IW'(12): rec_byte = count16[7:0];
      default: rec_byte = BYTE_ZERO;
    endcase
    if (idx >= IW'(REC_PRE)) begin
      if (off < IW'(sps_count)) begin
        rec_byte = rd_data;
      end else if (off == IW'(sps_count)) begin
        rec_byte = BYTE_ONE;
      end else if (off == IW'(sps_count) + IW'(1)) begin
        rec_byte = q.hdr_len[15:8];
      end else begin
        rec_byte = q.hdr_len[7:0];
      end
    end
  end

  // frame header byte at idx
  always_comb begin
    case (idx)
      IW'(0):  frm_byte = q.tag;
      IW'(1):  frm_byte = BYTE_ONE;
      IW'(6):  frm_byte = q.hdr_len[23:16];
      IW'(7):  frm_byte = q.hdr_len[15:8];
      IW'(8):  frm_byte = q.hdr_len[7:0];
      default: frm_byte = BYTE_ZERO;
    endcase
  end

  // next state and index
  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (acc && dec.rec) begin
          state_next = ST_REC;
        end else if (acc && dec.frm) begin
          state_next = ST_FRM;
        end
      end
      ST_REC: begin
        if (out_ok) begin
          idx_next = idx + IW'(1);
          if (idx == rec_end) begin
            idx_next   = '0;
            state_next = q.data ? ST_DATA : ST_IDLE;
          end
        end
      end
      ST_FRM: begin
        if (out_ok) begin
          idx_next = idx + IW'(1);
          if (idx == IW'(FRM_HDR - 1)) begin
            idx_next   = '0;
            state_next = q.data ? ST_DATA : ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (out_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // store address for the byte that follows: ahead of idx by one read
  always_comb begin
    if (idx_next < IW'(REC_PRE)) begin
      rd_addr = AW'(idx_next - IW'(5));
    end else begin
      rd_addr = AW'(idx_next - IW'(REC_PRE));
    end
  end

  // output selection
  always_comb begin
    emit    = 1'b0;
    e_byte  = q.byte_val;
    e_first = 1'b0;
    e_last  = q.last;
    e_kind  = q.kind;
    e_trunc = q.trunc;
    e_blen  = '0;
    case (state)
      ST_IDLE: begin
        emit    = acc && dec.data && !dec.rec && !dec.frm;
        e_byte  = dec.byte_val;
        e_last  = dec.last;
        e_kind  = dec.kind;
        e_trunc = dec.trunc;
      end
      ST_REC: begin
        emit    = out_ok;
        e_byte  = rec_byte;
        e_first = (idx == '0);
        e_last  = (idx == rec_end) && q.last && !q.data;
        e_blen  = (idx == '0) ? q.body_len : 24'd0;
      end
      ST_FRM: begin
        emit    = out_ok;
        e_byte  = frm_byte;
        e_first = (idx == '0);
        e_last  = (idx == IW'(FRM_HDR - 1)) && q.last && !q.data;
        e_blen  = (idx == '0) ? q.body_len : 24'd0;
      end
      ST_DATA: begin
        emit = out_ok;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q <= dec;
    end
    if (emit) begin
      out_byte      <= e_byte;
      packet_first  <= e_first;
      packet_last   <= e_last;
      packet_kind   <= e_kind;
      body_length   <= e_blen;
      sps_truncated <= e_trunc;
    end
  end

endmodule

FILE: src/h264_nal_to_flv_video_tag.sv
// H.264 Annex-B NAL bytes in, FLV AVC video tag body bytes out.
// Payload bytes: one transfer a cycle unless output stalls; out in the cycle after input.
// Frame header: 9 output bytes, stalling input; record header: 16 + SPS count bytes.
// SPS bytes: one a cycle unless output stalls; no output. SPS store: synchronous RAM,
// one write and one read port, read one entry ahead of the sequencer. rst (sync, active
// high) clears control state only; store contents stay undefined until an SPS is written.
module h264_nal_to_flv_video_tag #(
  parameter int SPS_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input stream: tdata = nal_length[23:0], byte_value[31:24]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [4:0]  s_tuser,   // nal_type
  input  logic        s_tlast,   // byte_last
  // output stream: tdata = out_byte[7:0], packet_first[8], body_length[32:9], zeros
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic [1:0]  m_tuser,   // packet_kind[0], sps_truncated[1]
  output logic        m_tlast    // packet_last
);
  import h2f_pkg::*;

  localparam int CW = $clog2(SPS_MAX + 1);
  localparam int AW = $clog2(SPS_MAX);
  localparam int IW = $clog2(SPS_MAX + REC_FIXED + 1);

  logic          acc;
  h2f_dec_t      dec;
  logic          we;
  logic [AW-1:0] waddr, rd_addr;
  logic [7:0]    wdata, rd_data;
  logic [CW-1:0] sps_count;
  logic          idle_ok;

  logic [7:0]    out_byte;
  logic          packet_first, packet_kind, sps_truncated;
  logic [23:0]   body_length;

  // one transfer in at a time; the sequencer holds input off during headers
  assign s_tready = idle_ok;
  assign acc      = s_tvalid && s_tready;

  h2f_parse #(
    .SPS_MAX (SPS_MAX),
    .CW      (CW),
    .AW      (AW)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .nal_type   (s_tuser),
    .nal_length (s_tdata[23:0]),
    .byte_value (s_tdata[31:24]),
    .byte_last  (s_tlast),
    .dec        (dec),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .sps_count  (sps_count)
  );

  h2f_sps_mem #(
    .DEPTH (SPS_MAX),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  h2f_emit #(
    .CW (CW),
    .AW (AW),
    .IW (IW)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .acc           (acc),
    .dec           (dec),
    .sps_count     (sps_count),
    .rd_data       (rd_data),
    .rd_addr       (rd_addr),
    .idle_ok       (idle_ok),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .out_byte      (out_byte),
    .packet_first  (packet_first),
    .packet_last   (m_tlast),
    .packet_kind   (packet_kind),
    .body_length   (body_length),
    .sps_truncated (sps_truncated)
  );

  assign m_tdata = {7'd0, body_length, packet_first, out_byte};
  assign m_tuser = {sps_truncated, packet_kind};

endmodule
